[hw/rtl/vna_pkg.sv]
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types, command codes and saturating arithmetic for the vertex
// normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int VNA_VERTEX_COUNT = 1024;

  localparam int IDX_W   = 10;
  localparam int POS_W   = 24;
  localparam int SUM_W   = 56;
  localparam int DIFF_W  = 25;
  localparam int PROD_W  = 50;
  localparam int CROSS_W = 51;

  // command codes of the input channel
  localparam logic [1:0] CMD_STORE = 2'd0;
  localparam logic [1:0] CMD_FACE  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // classified operations handed from front to back
  typedef enum logic [1:0] {
    OP_STORE,
    OP_FACE,
    OP_READ,
    OP_READ_OOR
  } op_t;

  typedef enum logic [3:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_FACE_RB,
    BK_FACE_RC,
    BK_FACE_DIFF,
    BK_FACE_MUL,
    BK_FACE_CROSS,
    BK_SUM_RD,
    BK_SUM_WR,
    BK_READ_WAIT
  } bk_state_t;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [IDX_W-1:0]        vert_a;
    logic [IDX_W-1:0]        vert_b;
    logic [IDX_W-1:0]        vert_c;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } vna_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_index;
    logic signed [POS_W-1:0] out_x;
    logic signed [POS_W-1:0] out_y;
    logic signed [POS_W-1:0] out_z;
    logic signed [SUM_W-1:0] normal_x;
    logic signed [SUM_W-1:0] normal_y;
    logic signed [SUM_W-1:0] normal_z;
  } vna_out_t;

  // queue entry between front and back
  typedef struct packed {
    op_t                     op;
    logic [IDX_W-1:0]        vert_a;
    logic [IDX_W-1:0]        vert_b;
    logic [IDX_W-1:0]        vert_c;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } vna_entry_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] x;
    logic signed [SUM_W-1:0] y;
    logic signed [SUM_W-1:0] z;
  } sum_t;

  // add with clamp to the 56-bit signed range
  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0]   acc,
    input logic signed [CROSS_W-1:0] inc
  );
    logic signed [SUM_W:0] s;
    s = (SUM_W+1)'(acc) + (SUM_W+1)'(inc);
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = s[SUM_W-1:0];
    end
  endfunction

endpackage

[hw/rtl/vna_ram.sv]
// ----------------------------------------------------------------------------
// vna_ram
// Generic memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/vna_front.sv]
// ----------------------------------------------------------------------------
// vna_front
// Accepts input beats, checks index ranges, drops commands without effect
// and queues the rest for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module vna_front
  import vna_pkg::*;
#(
  parameter int VERTEX_COUNT = VNA_VERTEX_COUNT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  vna_in_t    in_data,
  input  logic       clear_done,
  output logic       q_valid,
  output vna_entry_t q_entry,
  input  logic       q_pop
);

  vna_entry_t q_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  logic       a_ok, b_ok, c_ok;
  logic       keep;
  logic       push;
  vna_entry_t ent;

  // index range checks
  assign a_ok = 32'(in_data.vert_a) < VERTEX_COUNT;
  assign b_ok = 32'(in_data.vert_b) < VERTEX_COUNT;
  assign c_ok = 32'(in_data.vert_c) < VERTEX_COUNT;

  // classify the beat
  always_comb begin
    ent.vert_a = in_data.vert_a;
    ent.vert_b = in_data.vert_b;
    ent.vert_c = in_data.vert_c;
    ent.pos_x  = in_data.pos_x;
    ent.pos_y  = in_data.pos_y;
    ent.pos_z  = in_data.pos_z;
    ent.op     = OP_STORE;
    keep       = 1'b0;
    unique case (in_data.cmd)
      CMD_STORE: begin
        ent.op = OP_STORE;
        keep   = a_ok;
      end
      CMD_FACE: begin
        ent.op = OP_FACE;
        keep   = a_ok && b_ok && c_ok;
      end
      CMD_READ: begin
        ent.op = a_ok ? OP_READ : OP_READ_OOR;
        keep   = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready = clear_done && (cnt_r != 2'd2);
  assign push     = in_valid && in_ready && keep;

  assign q_valid = (cnt_r != 2'd0);
  assign q_entry = q_r[rptr_r];

  // queue pointers
  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = q_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= ent;
    end
  end

endmodule

[hw/rtl/vna_back.sv]
// ----------------------------------------------------------------------------
// vna_back
// Executes queued operations against the position and normal memories:
// clearing pass after reset, stores, face cross products with saturating
// accumulation, and reads into the output register.
// ----------------------------------------------------------------------------
module vna_back
  import vna_pkg::*;
#(
  parameter int VERTEX_COUNT = VNA_VERTEX_COUNT,
  localparam int AW = $clog2(VERTEX_COUNT)
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  vna_entry_t q_entry,
  output logic       q_pop,
  output logic       clear_done,
  output logic       out_valid,
  input  logic       out_ready,
  output vna_out_t   out_data
);

  bk_state_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [1:0]    corner_r, corner_nxt;

  logic [AW-1:0]    ia_r, ib_r, ic_r;
  logic [IDX_W-1:0] rd_idx_r;
  pos_t             pa_r, pb_r;
  logic signed [DIFF_W-1:0]  ux_r, uy_r, uz_r, vx_r, vy_r, vz_r;
  logic signed [PROD_W-1:0]  m0_r, m1_r, m2_r, m3_r, m4_r, m5_r;
  logic signed [CROSS_W-1:0] nx_r, ny_r, nz_r;

  logic          c_we;
  logic [AW-1:0] c_waddr, c_raddr;
  pos_t          c_wdata, c_rdata;
  logic          s_we;
  logic [AW-1:0] s_waddr, s_raddr;
  sum_t          s_wdata, s_rdata;

  logic     out_valid_r;
  vna_out_t out_data_r, out_nxt;
  logic     load_out;
  logic     out_free;
  logic     latch_face;
  logic     latch_read;
  logic [AW-1:0] cur_idx;

  assign out_free   = !out_valid_r || out_ready;
  assign clear_done = (state_r != BK_CLEAR);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  // corner being accumulated
  always_comb begin
    unique case (corner_r)
      2'd0:    cur_idx = ia_r;
      2'd1:    cur_idx = ib_r;
      default: cur_idx = ic_r;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    corner_nxt = corner_r;
    q_pop      = 1'b0;
    c_we       = 1'b0;
    c_waddr    = AW'(q_entry.vert_a);
    c_wdata    = {q_entry.pos_x, q_entry.pos_y, q_entry.pos_z};
    c_raddr    = AW'(q_entry.vert_a);
    s_we       = 1'b0;
    s_waddr    = AW'(q_entry.vert_a);
    s_wdata    = '0;
    s_raddr    = AW'(q_entry.vert_a);
    load_out   = 1'b0;
    out_nxt    = out_data_r;
    latch_face = 1'b0;
    latch_read = 1'b0;
    unique case (state_r)
      BK_CLEAR: begin
        s_we    = 1'b1;
        s_waddr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(VERTEX_COUNT - 1)) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid) begin
          unique case (q_entry.op)
            OP_STORE: begin
              q_pop = 1'b1;
              c_we  = 1'b1;
              s_we  = 1'b1;
            end
            OP_FACE: begin
              q_pop      = 1'b1;
              latch_face = 1'b1;
              state_nxt  = BK_FACE_RB;
            end
            OP_READ: begin
              if (out_free) begin
                q_pop      = 1'b1;
                latch_read = 1'b1;
                state_nxt  = BK_READ_WAIT;
              end
            end
            default: begin
              if (out_free) begin
                q_pop     = 1'b1;
                load_out  = 1'b1;
                out_nxt   = '0;
                out_nxt.out_index = q_entry.vert_a;
              end
            end
          endcase
        end
      end
      BK_FACE_RB: begin
        c_raddr   = ib_r;
        state_nxt = BK_FACE_RC;
      end
      BK_FACE_RC: begin
        c_raddr   = ic_r;
        state_nxt = BK_FACE_DIFF;
      end
      BK_FACE_DIFF: begin
        state_nxt = BK_FACE_MUL;
      end
      BK_FACE_MUL: begin
        state_nxt = BK_FACE_CROSS;
      end
      BK_FACE_CROSS: begin
        corner_nxt = 2'd0;
        state_nxt  = BK_SUM_RD;
      end
      BK_SUM_RD: begin
        s_raddr   = cur_idx;
        state_nxt = BK_SUM_WR;
      end
      BK_SUM_WR: begin
        s_we    = 1'b1;
        s_waddr = cur_idx;
        s_wdata = {sat_add(s_rdata.x, nx_r), sat_add(s_rdata.y, ny_r),
                   sat_add(s_rdata.z, nz_r)};
        if (corner_r == 2'd2) begin
          state_nxt = BK_IDLE;
        end else begin
          corner_nxt = corner_r + 2'd1;
          state_nxt  = BK_SUM_RD;
        end
      end
      BK_READ_WAIT: begin
        load_out           = 1'b1;
        out_nxt.out_index  = rd_idx_r;
        out_nxt.out_x      = c_rdata.x;
        out_nxt.out_y      = c_rdata.y;
        out_nxt.out_z      = c_rdata.z;
        out_nxt.normal_x   = s_rdata.x;
        out_nxt.normal_y   = s_rdata.y;
        out_nxt.normal_z   = s_rdata.z;
        state_nxt          = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_r       <= '0;
      corner_r    <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      corner_r <= corner_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // face datapath: positions, edges, products, cross product
  always_ff @(posedge clk) begin
    if (latch_face) begin
      ia_r <= AW'(q_entry.vert_a);
      ib_r <= AW'(q_entry.vert_b);
      ic_r <= AW'(q_entry.vert_c);
    end
    if (latch_read) begin
      rd_idx_r <= q_entry.vert_a;
    end
    if (load_out) begin
      out_data_r <= out_nxt;
    end
    if (state_r == BK_FACE_RB) begin
      pa_r <= c_rdata;
    end
    if (state_r == BK_FACE_RC) begin
      pb_r <= c_rdata;
    end
    if (state_r == BK_FACE_DIFF) begin
      ux_r <= DIFF_W'(pb_r.x) - DIFF_W'(pa_r.x);
      uy_r <= DIFF_W'(pb_r.y) - DIFF_W'(pa_r.y);
      uz_r <= DIFF_W'(pb_r.z) - DIFF_W'(pa_r.z);
      vx_r <= DIFF_W'(c_rdata.x) - DIFF_W'(pa_r.x);
      vy_r <= DIFF_W'(c_rdata.y) - DIFF_W'(pa_r.y);
      vz_r <= DIFF_W'(c_rdata.z) - DIFF_W'(pa_r.z);
    end
    if (state_r == BK_FACE_MUL) begin
      m0_r <= PROD_W'(uy_r) * PROD_W'(vz_r);
      m1_r <= PROD_W'(uz_r) * PROD_W'(vy_r);
      m2_r <= PROD_W'(uz_r) * PROD_W'(vx_r);
      m3_r <= PROD_W'(ux_r) * PROD_W'(vz_r);
      m4_r <= PROD_W'(ux_r) * PROD_W'(vy_r);
      m5_r <= PROD_W'(uy_r) * PROD_W'(vx_r);
    end
    if (state_r == BK_FACE_CROSS) begin
      nx_r <= CROSS_W'(m0_r) - CROSS_W'(m1_r);
      ny_r <= CROSS_W'(m2_r) - CROSS_W'(m3_r);
      nz_r <= CROSS_W'(m4_r) - CROSS_W'(m5_r);
    end
  end

  // position memory
  vna_ram #(
    .WIDTH ($bits(pos_t)),
    .DEPTH (VERTEX_COUNT)
  ) u_coord_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  // normal sum memory
  vna_ram #(
    .WIDTH ($bits(sum_t)),
    .DEPTH (VERTEX_COUNT)
  ) u_sum_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // queue is drained only from the idle state
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == BK_IDLE)
    else $error("queue popped outside idle");

  // output register never overwritten while a result waits
  a_out_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

  // no item enters while the clearing pass runs
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_CLEAR |-> !q_pop && !c_we)
    else $error("work during clearing pass");

  // a read fetch is always followed by an output load
  a_read_loads: assert property (@(posedge clk) disable iff (!rst_n)
    latch_read |=> load_out)
    else $error("read result not loaded");

endmodule

[hw/rtl/vertex_normal_accumulator.sv]
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// Vertex position table with area-weighted normal accumulation.
// ----------------------------------------------------------------------------
// After reset the block zeroes the normal memory, one vertex per cycle, and
// accepts no beat until that pass is done. In the back end a face takes
// three position reads on the single read port of the position memory, an
// edge, a product and a cross-product stage, and a read-modify-write of
// each corner's normal in the normal memory. A two-entry queue lets
// input beats be taken while the back end works and while a read result
// waits in the output register.
// Position reads of vertices never stored return unspecified data.
module vertex_normal_accumulator
  import vna_pkg::*;
#(
  parameter int VERTEX_COUNT = VNA_VERTEX_COUNT
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  vna_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output vna_out_t out_data
);

  logic       q_valid;
  vna_entry_t q_entry;
  logic       q_pop;
  logic       clear_done;

  // accept and classify
  vna_front #(
    .VERTEX_COUNT (VERTEX_COUNT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .clear_done (clear_done),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop)
  );

  // execute against the memories
  vna_back #(
    .VERTEX_COUNT (VERTEX_COUNT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .clear_done (clear_done),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the vertex normal accumulator. Stores, faces and reads are
// sent through the input channel and checked against a local model of the
// position and normal tables. Reads are checked field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import vna_pkg::*;

  localparam int NVERT       = VNA_VERTEX_COUNT;
  localparam int STALL_LIMIT = 20000;

  // command code with no effect
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  vna_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  vna_out_t out_data;

  // local copy of the block state
  logic signed [POS_W-1:0] pos_tab [3][NVERT];
  logic signed [SUM_W-1:0] nrm_tab [3][NVERT];
  bit                      stored  [NVERT];
  vna_out_t                pending_reads[$];

  int  error_count;
  int  idle_cycles;
  bit  timed_out;
  int  burst_left;

  vertex_normal_accumulator u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [SUM_W-1:0] clamp_add(
    input logic signed [SUM_W-1:0] acc,
    input logic signed [63:0]      inc
  );
    logic signed [63:0] s;
    s = 64'(acc) + inc;
    if (s > 64'sh007F_FFFF_FFFF_FFFF) s = 64'sh007F_FFFF_FFFF_FFFF;
    if (s < -64'sh0080_0000_0000_0000) s = -64'sh0080_0000_0000_0000;
    return s[SUM_W-1:0];
  endfunction

  // apply one command to the tables, queue a read result if any
  task automatic predict_beat(input vna_in_t b);
    logic signed [63:0] u [3];
    logic signed [63:0] v [3];
    logic signed [63:0] n [3];
    int                 corner [3];
    vna_out_t           r;
    case (b.cmd)
      CMD_STORE: begin
        if (b.vert_a < NVERT) begin
          pos_tab[0][b.vert_a] = b.pos_x;
          pos_tab[1][b.vert_a] = b.pos_y;
          pos_tab[2][b.vert_a] = b.pos_z;
          for (int k = 0; k < 3; k++) nrm_tab[k][b.vert_a] = '0;
          stored[b.vert_a] = 1'b1;
        end
      end
      CMD_FACE: begin
        if (b.vert_a < NVERT && b.vert_b < NVERT && b.vert_c < NVERT) begin
          corner = '{b.vert_a, b.vert_b, b.vert_c};
          for (int k = 0; k < 3; k++) begin
            u[k] = 64'(pos_tab[k][corner[1]]) - 64'(pos_tab[k][corner[0]]);
            v[k] = 64'(pos_tab[k][corner[2]]) - 64'(pos_tab[k][corner[0]]);
          end
          n[0] = u[1] * v[2] - u[2] * v[1];
          n[1] = u[2] * v[0] - u[0] * v[2];
          n[2] = u[0] * v[1] - u[1] * v[0];
          for (int j = 0; j < 3; j++)
            for (int k = 0; k < 3; k++)
              nrm_tab[k][corner[j]] = clamp_add(nrm_tab[k][corner[j]], n[k]);
        end
      end
      CMD_READ: begin
        r = '0;
        r.out_index = b.vert_a;
        if (b.vert_a < NVERT) begin
          r.out_x = pos_tab[0][b.vert_a];
          r.out_y = pos_tab[1][b.vert_a];
          r.out_z = pos_tab[2][b.vert_a];
          r.normal_x = nrm_tab[0][b.vert_a];
          r.normal_y = nrm_tab[1][b.vert_a];
          r.normal_z = nrm_tab[2][b.vert_a];
        end
        pending_reads.insert(pending_reads.size(), r);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    error_count++;
  endtask

  // send one beat with burst/gap pacing
  task automatic send_beat(input vna_in_t b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_beat(b);
  endtask

  function automatic int pick_stored();
    int i;
    do i = $urandom_range(0, 63); while (!stored[i]);
    return i;
  endfunction

  function automatic logic signed [POS_W-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 24'sh7FFFFF;
      1: return -24'sh800000;
      2: return POS_W'($signed($urandom_range(0, 16383)) - 8192);
      default: return POS_W'($urandom);
    endcase
  endfunction

  function automatic vna_in_t make_cmd(input logic [1:0] c, input int a,
                                       input int b, input int cc);
    vna_in_t t;
    t = '0;
    t.cmd = c; t.vert_a = IDX_W'(a); t.vert_b = IDX_W'(b); t.vert_c = IDX_W'(cc);
    return t;
  endfunction

  task automatic store_vertex(input int a, input logic signed [POS_W-1:0] x,
                              input logic signed [POS_W-1:0] y,
                              input logic signed [POS_W-1:0] z);
    vna_in_t t;
    t = make_cmd(CMD_STORE, a, $urandom, $urandom);
    t.pos_x = x; t.pos_y = y; t.pos_z = z;
    send_beat(t);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reads.size() != 0 && !timed_out) @(posedge clk);
  endtask

  // extremes, saturation, repeated corners, cmd 3
  task automatic test_directed();
    store_vertex(0, 0, 0, 0);
    store_vertex(1, 24'sh7FFFFF, -24'sh800000, 0);
    store_vertex(2, -24'sh800000, 0, 24'sh7FFFFF);
    store_vertex(NVERT-1, 24'sh7FFFFF, 24'sh7FFFFF, -24'sh800000);
    for (int k = 0; k < 6; k++) send_beat(make_cmd(CMD_FACE, 0, 1, 2));
    send_beat(make_cmd(CMD_FACE, 1, 2, NVERT-1));
    send_beat(make_cmd(CMD_FACE, 1, 1, 2));
    send_beat(make_cmd(CMD_FACE, 0, 0, 0));
    send_beat(make_cmd(CMD_READ, 0, 0, 0));
    send_beat(make_cmd(CMD_READ, 1, 0, 0));
    send_beat(make_cmd(CMD_READ, 2, 0, 0));
    send_beat(make_cmd(CMD_READ, NVERT-1, 0, 0));
    send_beat(make_cmd(CMD_UNUSED, 1, 2, 0));
    send_beat(make_cmd(CMD_READ, 1, 0, 0));
    store_vertex(1, 24'sh000123, 24'sh000456, -24'sh000789);
    send_beat(make_cmd(CMD_READ, 1, 0, 0));
    // full-range right triangle drives the z normal into the upper clamp
    store_vertex(4, -24'sh800000, -24'sh800000, -24'sh800000);
    store_vertex(5, 24'sh7FFFFF, -24'sh800000, -24'sh800000);
    store_vertex(6, -24'sh800000, 24'sh7FFFFF, -24'sh800000);
    for (int k = 0; k < 130; k++) send_beat(make_cmd(CMD_FACE, 4, 5, 6));
    for (int k = 4; k < 7; k++) send_beat(make_cmd(CMD_READ, k, 0, 0));
    // same triangle wound the other way into the lower clamp
    store_vertex(4, -24'sh800000, -24'sh800000, -24'sh800000);
    store_vertex(5, 24'sh7FFFFF, -24'sh800000, -24'sh800000);
    store_vertex(6, -24'sh800000, 24'sh7FFFFF, -24'sh800000);
    for (int k = 0; k < 130; k++) send_beat(make_cmd(CMD_FACE, 4, 6, 5));
    for (int k = 4; k < 7; k++) send_beat(make_cmd(CMD_READ, k, 0, 0));
    wait_drained();
  endtask

  // random mix over a small vertex set so faces pile up on shared corners
  task automatic test_random(input int count);
    vna_in_t t;
    int      sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
        store_vertex($urandom_range(0, 63), rand_coord(), rand_coord(), rand_coord());
      end else if (sel < 65) begin
        send_beat(make_cmd(CMD_FACE, pick_stored(), pick_stored(), pick_stored()));
      end else if (sel < 95) begin
        send_beat(make_cmd(CMD_READ, pick_stored(), $urandom, $urandom));
      end else begin
        t = $bits(vna_in_t)'({$urandom, $urandom, $urandom, $urandom});
        // in-range corners must name stored vertices
        if (t.cmd == CMD_FACE || t.cmd == CMD_READ) begin
          if (int'(t.vert_a) < NVERT) t.vert_a = IDX_W'(pick_stored());
          if (t.cmd == CMD_FACE) begin
            if (int'(t.vert_b) < NVERT) t.vert_b = IDX_W'(pick_stored());
            if (int'(t.vert_c) < NVERT) t.vert_c = IDX_W'(pick_stored());
          end
        end
        if (t.cmd == CMD_STORE) t.vert_a = IDX_W'($urandom_range(0, 63));
        send_beat(t);
      end
      if (i == count / 2) wait_drained();
    end
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else case (($urandom_range(0, 3) == 0) ? 0 : 1)
      0: out_ready <= ~out_ready;
      default: out_ready <= out_ready | ($urandom_range(0, 1) == 1);
    endcase
  end

  // result checker
  always @(posedge clk) begin
    vna_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reads.size() == 0) begin
        report_mismatch("unexpected beat", 64'(out_data.out_index), 64'd0);
      end else begin
        want = pending_reads.pop_front();
        if (out_data.out_index !== want.out_index)
          report_mismatch("out_index", 64'(out_data.out_index), 64'(want.out_index));
        if (out_data.out_x !== want.out_x)
          report_mismatch("out_x", 64'(out_data.out_x), 64'(want.out_x));
        if (out_data.out_y !== want.out_y)
          report_mismatch("out_y", 64'(out_data.out_y), 64'(want.out_y));
        if (out_data.out_z !== want.out_z)
          report_mismatch("out_z", 64'(out_data.out_z), 64'(want.out_z));
        if (out_data.normal_x !== want.normal_x)
          report_mismatch("normal_x", 64'(out_data.normal_x), 64'(want.normal_x));
        if (out_data.normal_y !== want.normal_y)
          report_mismatch("normal_y", 64'(out_data.normal_y), 64'(want.normal_y));
        if (out_data.normal_z !== want.normal_z)
          report_mismatch("normal_z", 64'(out_data.normal_z), 64'(want.normal_z));
      end
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    error_count = 0;
    burst_left  = 0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    for (int i = 0; i < NVERT; i++) begin
      stored[i] = 1'b0;
      for (int k = 0; k < 3; k++) begin
        pos_tab[k][i] = '0;
        nrm_tab[k][i] = '0;
      end
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(1060);
    wait_drained();
    repeat (50) @(posedge clk);
    if (error_count == 0 && pending_reads.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
